// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rbn_pkg.sv -----
// ----------------------------------------------------------------------------
// rbn_pkg
// Types, constants and width helpers for the fractional-edge rebinning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbn_pkg;

  localparam int MAX_SAMPLES_DEF   = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SAMPLE_W = 31;
  localparam int EDGE_W   = 28;
  localparam int SUM_W    = 59;
  localparam int OFFSET_W = 12;
  localparam int INDEX_W  = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic [INDEX_W-1:0] CFG_START_OFFSET = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_DOWNWARD     = 2'd1;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] sample_value;
    logic [EDGE_W-1:0]   edge_position;
    logic                last_bin;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] bin_sum;
    logic             edge_error;
    logic             last;
  } out_item_t;

  function automatic int cnt_width(input int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  function automatic int pos_width(input int max_samples, input int fraction_bits);
    int w;
    w = $clog2(max_samples + 1) + fraction_bits;
    return (w > EDGE_W) ? w : EDGE_W;
  endfunction

endpackage

// ----- rtl/rbn_store.sv -----
// ----------------------------------------------------------------------------
// rbn_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbn_store #(
  parameter int MAX_SAMPLES = rbn_pkg::MAX_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(MAX_SAMPLES)-1:0]   waddr,
  input  logic [rbn_pkg::SAMPLE_W-1:0]     wdata,
  input  logic                             re,
  input  logic [$clog2(MAX_SAMPLES)-1:0]   raddr,
  output logic [rbn_pkg::SAMPLE_W-1:0]     rdata
);

  logic [rbn_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rbn_walk.sv -----
// ----------------------------------------------------------------------------
// rbn_walk
// Walks the sample cells of one bin: reads each sample, weights it by its
// overlap with the bin, and accumulates a saturating sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbn_walk #(
  parameter int MAX_SAMPLES   = rbn_pkg::MAX_SAMPLES_DEF,
  parameter int FRACTION_BITS = rbn_pkg::FRACTION_BITS_DEF,
  localparam int CNT_W  = rbn_pkg::cnt_width(MAX_SAMPLES),
  localparam int POS_W  = rbn_pkg::pos_width(MAX_SAMPLES, FRACTION_BITS),
  localparam int AW     = $clog2(MAX_SAMPLES)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [POS_W-1:0]               lo,
  input  logic [POS_W-1:0]               hi,
  input  logic [CNT_W-1:0]               n,
  input  logic [rbn_pkg::OFFSET_W-1:0]   offset,
  output logic                           done,
  output logic [rbn_pkg::SUM_W-1:0]      sum,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr,
  input  logic [rbn_pkg::SAMPLE_W-1:0]   rd_data
);

  localparam int IW     = POS_W - FRACTION_BITS;
  localparam int AF     = ((rbn_pkg::OFFSET_W > IW) ? rbn_pkg::OFFSET_W : IW) + 1;
  localparam int PROD_W = rbn_pkg::SAMPLE_W + FRACTION_BITS + 1;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_RUN   = 3'b010,
    W_DRAIN = 3'b100
  } wstate_t;

  wstate_t                  state;
  logic [IW-1:0]            idx;
  logic                     v0;
  logic                     pv;
  logic [FRACTION_BITS:0]   ov0;
  logic [PROD_W-1:0]        prod;
  logic [rbn_pkg::SUM_W-1:0] acc;

  logic [IW-1:0]            lo_int;
  logic [IW-1:0]            hi_int;
  logic [FRACTION_BITS-1:0] lo_frac;
  logic [FRACTION_BITS-1:0] hi_frac;
  logic                     cond;
  logic                     first_cell;
  logic                     last_cell;
  logic [FRACTION_BITS:0]   overlap;
  logic [AF-1:0]            addr_full;
  logic [rbn_pkg::SUM_W:0]  acc_next;

  assign lo_int  = lo[POS_W-1:FRACTION_BITS];
  assign hi_int  = hi[POS_W-1:FRACTION_BITS];
  assign lo_frac = lo[FRACTION_BITS-1:0];
  assign hi_frac = hi[FRACTION_BITS-1:0];

  assign first_cell = (idx == lo_int);
  assign last_cell  = (idx == hi_int);
  assign cond = (idx < IW'(n)) &&
                ((idx < hi_int) || (last_cell && (hi_frac != '0)));

  always_comb begin
    if (first_cell && last_cell) begin
      overlap = {1'b0, hi_frac} - {1'b0, lo_frac};
    end else if (first_cell) begin
      overlap = ONE - {1'b0, lo_frac};
    end else if (last_cell) begin
      overlap = {1'b0, hi_frac};
    end else begin
      overlap = ONE;
    end
  end

  assign addr_full = AF'(offset) + AF'(idx);
  assign rd_addr   = addr_full[AW-1:0];
  assign rd_en     = (state == W_RUN) && cond;

  assign acc_next = {1'b0, acc} + (rbn_pkg::SUM_W + 1)'(prod);
  assign done     = (state == W_DRAIN) && !v0 && !pv;
  assign sum      = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      v0    <= 1'b0;
      pv    <= 1'b0;
    end else begin
      pv <= v0;
      v0 <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (go) begin
            state <= W_RUN;
          end
        end
        W_RUN: begin
          if (cond) begin
            v0 <= 1'b1;
          end else begin
            state <= W_DRAIN;
          end
        end
        W_DRAIN: begin
          if (!v0 && !pv) begin
            state <= W_IDLE;
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= rd_data * ov0;
    if ((state == W_IDLE) && go) begin
      idx <= lo_int;
      acc <= '0;
    end else begin
      if (rd_en) begin
        idx <= idx + 1'b1;
        ov0 <= overlap;
      end
      if (pv) begin
        if (acc_next[rbn_pkg::SUM_W]) begin
          acc <= '1;
        end else begin
          acc <= acc_next[rbn_pkg::SUM_W-1:0];
        end
      end
    end
  end

endmodule

// ----- rtl/count_rebinning_fractional_edges.sv -----
// ----------------------------------------------------------------------------
// count_rebinning_fractional_edges
// Flux-conserving rebinning of counter samples onto fractional bin edges.
// A load transaction (opcode 0) appends one sample while the store is not
// full; busy stays low. An edge transaction (opcode 1) closes one bin: busy
// stays high through the range, clamp and order steps and the walk, which
// reads each sample cell that the bin covers, if any, from the sample memory
// once per cycle through its single read port. The bin sum
// appears on result for one cycle, marked by result_valid, in the cycle busy
// drops; the receiver cannot stall and must take it then. Edges are Q12.16
// positions relative to start_offset; bin_sum is Q43.16 and saturates.
// Configuration writes are held off while busy or start is high, so they
// land only between transactions.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module count_rebinning_fractional_edges #(
  parameter int MAX_SAMPLES   = rbn_pkg::MAX_SAMPLES_DEF,
  parameter int FRACTION_BITS = rbn_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rbn_pkg::in_item_t             cmd,
  output logic                          result_valid,
  output rbn_pkg::out_item_t            result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbn_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [rbn_pkg::OFFSET_W-1:0]  cfg_data
);

  localparam int CNT_W = rbn_pkg::cnt_width(MAX_SAMPLES);
  localparam int POS_W = rbn_pkg::pos_width(MAX_SAMPLES, FRACTION_BITS);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int XW    = (CNT_W > rbn_pkg::OFFSET_W) ? CNT_W : rbn_pkg::OFFSET_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RANGE = 5'b00010,
    S_CLAMP = 5'b00100,
    S_ORDER = 5'b01000,
    S_WALK  = 5'b10000
  } state_t;

  state_t                         state;
  logic [CNT_W-1:0]               sample_total;
  logic [POS_W-1:0]               previous_edge;
  logic                           bin_open;
  logic [rbn_pkg::OFFSET_W-1:0]   start_offset;
  logic                           downward;
  logic                           walk_go;

  logic [rbn_pkg::EDGE_W-1:0]     edge_q;
  logic                           final_q;
  logic [CNT_W-1:0]               n_q;
  logic [POS_W-1:0]               start_q;
  logic [POS_W-1:0]               data_end_q;
  logic [POS_W-1:0]               e1_q;
  logic                           gt_q;
  logic                           err_q;
  logic [POS_W-1:0]               lo_q;
  logic [POS_W-1:0]               hi_q;

  logic                           accept;
  logic                           mem_we;
  logic [XW-1:0]                  total_ext;
  logic [XW-1:0]                  offset_ext;
  logic [POS_W-1:0]               data_end;
  logic [POS_W-1:0]               start_pos;
  logic [POS_W-1:0]               edge_ext;
  logic                           order_clamp;

  logic                           walk_done;
  logic [rbn_pkg::SUM_W-1:0]      walk_sum;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [rbn_pkg::SAMPLE_W-1:0]   rd_data;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign mem_we    = accept && (cmd.opcode == rbn_pkg::OP_LOAD) &&
                     (sample_total < CNT_W'(MAX_SAMPLES));

  assign total_ext  = XW'(sample_total);
  assign offset_ext = XW'(start_offset);
  assign data_end   = POS_W'(n_q) << FRACTION_BITS;
  assign start_pos  = bin_open ? previous_edge : (downward ? data_end : '0);
  assign edge_ext   = POS_W'(edge_q);
  assign order_clamp = downward ? (e1_q > start_q) : (e1_q < start_q);

  rbn_store #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (sample_total[AW-1:0]),
    .wdata (cmd.sample_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rbn_walk #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .go      (walk_go),
    .lo      (lo_q),
    .hi      (hi_q),
    .n       (n_q),
    .offset  (start_offset),
    .done    (walk_done),
    .sum     (walk_sum),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_total  <= '0;
      previous_edge <= '0;
      bin_open      <= 1'b0;
      start_offset  <= '0;
      downward      <= 1'b0;
      walk_go       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      walk_go      <= 1'b0;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rbn_pkg::CFG_START_OFFSET: start_offset <= cfg_data;
          rbn_pkg::CFG_DOWNWARD:     downward     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.opcode == rbn_pkg::OP_EDGE) begin
              state <= S_RANGE;
            end else if (mem_we) begin
              sample_total <= sample_total + 1'b1;
            end
          end
        end
        S_RANGE: begin
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          state <= S_ORDER;
        end
        S_ORDER: begin
          walk_go <= 1'b1;
          state   <= S_WALK;
          if (final_q) begin
            sample_total  <= '0;
            previous_edge <= '0;
            bin_open      <= 1'b0;
          end else begin
            previous_edge <= order_clamp ? start_q : e1_q;
            bin_open      <= 1'b1;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      edge_q  <= cmd.edge_position;
      final_q <= cmd.last_bin;
    end
    if (state == S_RANGE) begin
      if (total_ext > offset_ext) begin
        n_q <= CNT_W'(total_ext - offset_ext);
      end else begin
        n_q <= '0;
      end
    end
    if (state == S_CLAMP) begin
      start_q    <= start_pos;
      data_end_q <= data_end;
      gt_q       <= (start_pos > data_end);
      if (edge_ext > data_end) begin
        e1_q  <= data_end;
        err_q <= 1'b1;
      end else begin
        e1_q  <= edge_ext;
        err_q <= 1'b0;
      end
    end
    if (state == S_ORDER) begin
      if (final_q) begin
        err_q <= 1'b0;
        if (downward) begin
          lo_q <= '0;
          hi_q <= start_q;
        end else begin
          lo_q <= gt_q ? data_end_q : start_q;
          hi_q <= gt_q ? start_q : data_end_q;
        end
      end else if (order_clamp) begin
        err_q <= 1'b1;
        lo_q  <= start_q;
        hi_q  <= start_q;
      end else if (downward) begin
        lo_q <= e1_q;
        hi_q <= start_q;
      end else begin
        lo_q <= start_q;
        hi_q <= e1_q;
      end
    end
    if ((state == S_WALK) && walk_done) begin
      result.bin_sum    <= walk_sum;
      result.edge_error <= err_q;
      result.last       <= final_q;
    end
  end

endmodule

// ----- rtl/rbn_checker.sv -----
// ----------------------------------------------------------------------------
// rbn_checker
// Port-level checks of transaction timing and result flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbn_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input rbn_pkg::in_item_t   cmd,
  input logic                result_valid,
  input rbn_pkg::out_item_t  result
);

  `ASSERT_NEXT(a_load_single_cycle, clk, rst, start && !busy && cmd.opcode == rbn_pkg::OP_LOAD, !busy)
  `ASSERT_NEXT(a_edge_goes_busy, clk, rst, start && !busy && cmd.opcode == rbn_pkg::OP_EDGE, busy)
  `ASSERT_NEXT(a_result_one_cycle, clk, rst, result_valid, !result_valid)
  `ASSERT_SAME(a_result_when_idle, clk, rst, result_valid, !busy)
  `ASSERT_SAME(a_final_no_error, clk, rst, result_valid && result.last, !result.edge_error)

endmodule

bind count_rebinning_fractional_edges rbn_checker u_rbn_checker (.*);

// ----- dv/count_rebinning_fractional_edges_tb.sv -----
// ----------------------------------------------------------------------------
// count_rebinning_fractional_edges_tb
// Self-checking bench for the fractional-edge rebinning block. A driver feeds
// load and edge transactions from a queue of pending commands and predicts
// each bin sum, edge flag and final marker from its own copy of the sample
// store and registers. A monitor checks every result strobe against the
// oldest prediction. A short directed part covers empty data, extreme values,
// clamped and out-of-order edges and both scan directions. Randomized runs of
// loads and edges follow, under several sender idle rates and register
// settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module count_rebinning_fractional_edges_tb;

  localparam int              FRAC_BITS    = rbn_pkg::FRACTION_BITS_DEF;
  localparam int              STORE_DEPTH  = rbn_pkg::MAX_SAMPLES_DEF;
  localparam int              SAMPLE_BITS  = rbn_pkg::SAMPLE_W;
  localparam int              EDGE_BITS    = rbn_pkg::EDGE_W;
  localparam int              SUM_BITS     = rbn_pkg::SUM_W;
  localparam int              OFFSET_BITS  = rbn_pkg::OFFSET_W;
  localparam int              INDEX_BITS   = rbn_pkg::INDEX_W;
  localparam longint unsigned CELL         = 64'd1 << FRAC_BITS;
  localparam longint unsigned SUM_ALL_ONES = (64'd1 << SUM_BITS) - 64'd1;
  localparam longint unsigned EDGE_ALL_ONES = (64'd1 << EDGE_BITS) - 64'd1;
  localparam int              SETTLE_CYCLES = 32;
  localparam int              CYCLE_LIMIT   = 4000000;
  localparam int              RANDOM_PHASES = 8;
  localparam int              PHASE_ITEMS   = 180;
  localparam int unsigned     IDLE_PATTERN [4] = '{0, 80, 0, 32};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  rbn_pkg::in_item_t      cmd = '0;
  logic                   result_valid;
  rbn_pkg::out_item_t     result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [INDEX_BITS-1:0]  cfg_index = '0;
  logic [OFFSET_BITS-1:0] cfg_data = '0;

  count_rebinning_fractional_edges u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted block state
  bit [SAMPLE_BITS-1:0]   sample_mem [STORE_DEPTH];
  int                     stored_count = 0;
  longint unsigned        prev_edge = 0;
  bit                     bin_open = 1'b0;
  logic [OFFSET_BITS-1:0] offset_reg = '0;
  bit                     downward_reg = 1'b0;

  rbn_pkg::in_item_t    pending_cmds [$];
  rbn_pkg::out_item_t   expected_bins [$];
  rbn_pkg::out_item_t   predicted;
  rbn_pkg::out_item_t   want;

  int unsigned send_idle_pct = 0;
  int          gen_stored = 0;
  int          gen_items = 0;
  int          n_errors = 0;
  int          n_loads = 0;
  int          n_edges = 0;
  int          n_results = 0;
  int          n_flagged = 0;
  int          n_closed = 0;
  int          n_cfg_writes = 0;
  int          cycle_count = 0;

  function automatic void note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic longint unsigned data_length();
    return (stored_count > int'(offset_reg)) ? longint'(stored_count - int'(offset_reg)) : 0;
  endfunction

  function automatic longint unsigned overlap_weighted_sum(input longint unsigned a,
                                                           input longint unsigned b);
    longint unsigned lo, hi, n, idx, cell_lo, cell_hi, from, upto, term, acc;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    n   = data_length();
    acc = 0;
    idx = lo >> FRAC_BITS;
    while (idx < n && (idx << FRAC_BITS) < hi) begin
      cell_lo = idx << FRAC_BITS;
      cell_hi = cell_lo + CELL;
      from    = (lo > cell_lo) ? lo : cell_lo;
      upto    = (hi < cell_hi) ? hi : cell_hi;
      if (upto > from && longint'(offset_reg) + idx < STORE_DEPTH) begin
        term = longint'(sample_mem[longint'(offset_reg) + idx]) * (upto - from);
        if (acc > SUM_ALL_ONES - term) acc = SUM_ALL_ONES;
        else acc += term;
      end
      idx++;
    end
    return acc;
  endfunction

  // Advance the predicted state by one transaction; return 1 when a bin closes.
  function automatic bit predict_bin(input rbn_pkg::in_item_t it,
                                     output rbn_pkg::out_item_t res);
    longint unsigned data_end, bin_start, edge_pos;
    bit              err;
    res = '0;
    if (it.opcode == rbn_pkg::OP_LOAD) begin
      if (stored_count < STORE_DEPTH) begin
        sample_mem[stored_count] = it.sample_value;
        stored_count++;
      end
      return 1'b0;
    end
    data_end  = data_length() << FRAC_BITS;
    bin_start = bin_open ? prev_edge : (downward_reg ? data_end : 0);
    if (it.last_bin) begin
      res.bin_sum = SUM_BITS'(overlap_weighted_sum(bin_start, downward_reg ? 0 : data_end));
      res.last    = 1'b1;
      stored_count = 0;
      prev_edge    = 0;
      bin_open     = 1'b0;
      return 1'b1;
    end
    edge_pos = it.edge_position;
    err      = 1'b0;
    if (edge_pos > data_end) begin
      edge_pos = data_end;
      err      = 1'b1;
    end
    if (!downward_reg && edge_pos < bin_start) begin
      edge_pos = bin_start;
      err      = 1'b1;
    end else if (downward_reg && edge_pos > bin_start) begin
      edge_pos = bin_start;
      err      = 1'b1;
    end
    res.bin_sum    = SUM_BITS'(overlap_weighted_sum(bin_start, edge_pos));
    res.edge_error = err;
    prev_edge = edge_pos;
    bin_open  = 1'b1;
    return 1'b1;
  endfunction

  // Driver: hold a command until it is taken, then pick the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cmd.opcode == rbn_pkg::OP_LOAD) n_loads++;
        else n_edges++;
        if (predict_bin(cmd, predicted)) expected_bins.push_back(predicted);
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd   <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe consumes the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_bins.size() == 0) begin
        note_failure($sformatf("unexpected result: sum %h err %b last %b",
                               result.bin_sum, result.edge_error, result.last));
      end else begin
        want = expected_bins.pop_front();
        n_results++;
        n_flagged += result.edge_error;
        n_closed  += result.last;
        if (result.bin_sum !== want.bin_sum || result.edge_error !== want.edge_error ||
            result.last !== want.last) begin
          note_failure($sformatf("bin %0d: sum %h exp %h, err %b exp %b, last %b exp %b",
                                 n_results, result.bin_sum, want.bin_sum, result.edge_error,
                                 want.edge_error, result.last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bins outstanding", cycle_count,
               expected_bins.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_bins.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                           input logic [OFFSET_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rbn_pkg::CFG_START_OFFSET) offset_reg = val;
    else if (idx == rbn_pkg::CFG_DOWNWARD) downward_reg = val[0];
    n_cfg_writes++;
  endtask

  task automatic set_mode(input logic [OFFSET_BITS-1:0] offset, input bit down,
                          input int unsigned idle_pct);
    wait_idle();
    write_reg(rbn_pkg::CFG_START_OFFSET, offset);
    write_reg(rbn_pkg::CFG_DOWNWARD, {{(OFFSET_BITS-1){1'b0}}, down});
    send_idle_pct = idle_pct;
    @(negedge clk);
  endtask

  task automatic push_load(input logic [SAMPLE_BITS-1:0] value);
    rbn_pkg::in_item_t it;
    bit [31:0]         rnd;
    rnd              = $urandom;
    it.opcode        = rbn_pkg::OP_LOAD;
    it.sample_value  = value;
    it.edge_position = rnd[EDGE_BITS-1:0];
    it.last_bin      = rnd[31];
    pending_cmds.push_back(it);
    if (gen_stored < STORE_DEPTH) gen_stored++;
    gen_items++;
  endtask

  task automatic push_edge(input longint unsigned pos, input bit last);
    rbn_pkg::in_item_t it;
    bit [31:0]         rnd;
    rnd              = $urandom;
    it.opcode        = rbn_pkg::OP_EDGE;
    it.sample_value  = rnd[SAMPLE_BITS-1:0];
    it.edge_position = (pos > EDGE_ALL_ONES) ? '1 : pos[EDGE_BITS-1:0];
    it.last_bin      = last;
    pending_cmds.push_back(it);
    if (last) gen_stored = 0;
    gen_items++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    bit [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      default: return rnd[SAMPLE_BITS-1:0];
    endcase
  endfunction

  // One run: a burst of loads, a walk of edges in scan direction with some
  // noise, and usually the final bin.
  task automatic push_random_run();
    int unsigned     load_cnt, edge_cnt, stride_max, stride, back;
    longint unsigned span, pos;
    load_cnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1);
    repeat (load_cnt) push_load(random_sample());
    span = ((gen_stored > int'(offset_reg)) ? longint'(gen_stored - int'(offset_reg)) : 0)
           << FRAC_BITS;
    pos  = downward_reg ? span : 0;
    edge_cnt   = $urandom_range(8, 1);
    stride_max = 32'(span / edge_cnt * 2) + 32'hFFFF;
    repeat (edge_cnt) begin
      case ($urandom_range(19))
        0: push_edge($urandom & 32'hFFFFFFF, 1'b0);
        1: begin
          back = $urandom_range(stride_max, 1);
          push_edge(downward_reg ? pos + back : ((pos > back) ? pos - back : 0), 1'b0);
        end
        2: push_load(random_sample());
        default: begin
          stride = $urandom_range(stride_max);
          if (downward_reg) pos = (pos > stride) ? pos - stride : 0;
          else pos = pos + stride;
          push_edge(pos, 1'b0);
        end
      endcase
    end
    if (gen_stored > 300 || $urandom_range(7) != 0) push_edge($urandom & 32'hFFFFFFF, 1'b1);
  endtask

  initial begin
    int  base;
    bit  paused;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Upward scan from offset 0: empty data, extreme samples, clamping.
    set_mode('0, 1'b0, 0);
    push_edge(0, 1'b0);
    push_edge(EDGE_ALL_ONES, 1'b0);
    push_edge(EDGE_ALL_ONES, 1'b1);
    push_load('1);
    push_load('0);
    push_load(31'd1234567);
    push_load(31'h2AAAAAAA);
    push_edge(64'h8000, 1'b0);
    push_edge(64'h18000, 1'b0);
    push_edge(64'h10000, 1'b0);
    push_edge(EDGE_ALL_ONES, 1'b0);
    push_edge(EDGE_ALL_ONES, 1'b1);

    // Downward scan with offset 1: reversed intervals and order violations.
    set_mode(12'd1, 1'b1, 0);
    push_load(31'd100);
    push_load('1);
    push_load(31'd7);
    push_edge(64'h28000, 1'b0);
    push_edge(64'h18000, 1'b0);
    push_edge(64'h1C000, 1'b0);
    push_edge(64'h8000, 1'b0);
    push_edge(0, 1'b1);

    // Largest offset: all samples fall before the start.
    set_mode('1, 1'b0, 0);
    push_load('1);
    push_load(31'd5);
    push_edge(64'h10000, 1'b0);
    push_edge(0, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_mode((p == 0) ? '0 : OFFSET_BITS'($urandom_range(12)), p[0], IDLE_PATTERN[p % 4]);
      base   = gen_items;
      paused = 1'b0;
      while (gen_items - base < PHASE_ITEMS) begin
        // Hold off new commands once until every pending bin has returned.
        if (p == 2 && !paused && gen_items - base >= PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        push_random_run();
      end
    end

    wait_idle();
    $display("Ran %0d loads and %0d edge transactions with %0d register writes.",
             n_loads, n_edges, n_cfg_writes);
    $display("Checked %0d bins: %0d with a clamped edge, %0d closing a run.",
             n_results, n_flagged, n_closed);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- count_rebinning_fractional_edges.f -----
+incdir+rtl
rtl/rbn_pkg.sv
rtl/rbn_store.sv
rtl/rbn_walk.sv
rtl/count_rebinning_fractional_edges.sv
rtl/rbn_checker.sv
dv/count_rebinning_fractional_edges_tb.sv
